@@ design/pfla_pkg.sv @@
package pfla_pkg;

  localparam int PAGE_W     = 12;
  localparam int COUNT_W    = 13;
  localparam int PAGE_SPACE = 1 << PAGE_W;

  localparam int MAX_PAGES_DEF  = 4096;
  localparam int GROW_PAGES_DEF = 8;

  typedef enum logic {
    ACT_ALLOC = 1'b0,
    ACT_FREE  = 1'b1
  } action_t;

  typedef enum logic [1:0] {
    STAT_DONE    = 2'd0,
    STAT_FULL    = 2'd1,
    STAT_IGNORED = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_POP,
    ST_GROW
  } state_t;

  typedef struct packed {
    action_t             action;
    logic [PAGE_W-1:0]   page_number;
  } req_t;

  typedef struct packed {
    logic [PAGE_W-1:0]   allocated_page;
    status_t             status;
  } rsp_t;

  typedef struct packed {
    logic                valid;
    rsp_t                data;
  } result_t;

endpackage

@@ design/pfla_ram.sv @@
module pfla_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ design/pfla_core.sv @@
module pfla_core #(
  parameter int MAX_PAGES  = pfla_pkg::MAX_PAGES_DEF,
  parameter int GROW_PAGES = pfla_pkg::GROW_PAGES_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        fire,
  input  pfla_pkg::req_t              req,
  output logic                        idle,
  output pfla_pkg::result_t           res,
  output logic                        mem_we,
  output logic [pfla_pkg::PAGE_W-1:0] mem_waddr,
  output logic [pfla_pkg::PAGE_W-1:0] mem_wdata,
  output logic [pfla_pkg::PAGE_W-1:0] mem_raddr,
  input  logic [pfla_pkg::PAGE_W-1:0] mem_rdata
);

  localparam int CAP = (MAX_PAGES > pfla_pkg::PAGE_SPACE) ? pfla_pkg::PAGE_SPACE : MAX_PAGES;
  localparam int SUM_W = pfla_pkg::COUNT_W + 1;
  localparam int K_W = $clog2(GROW_PAGES);
  localparam logic [SUM_W-1:0] CAP_L = SUM_W'(CAP);
  localparam logic [SUM_W-1:0] GROW_L = SUM_W'(GROW_PAGES);
  localparam logic [K_W-1:0] K_LAST = K_W'(GROW_PAGES - 1);
  localparam logic [K_W-1:0] K_FIRST = K_W'(1);

  pfla_pkg::state_t state, state_next;

  logic [pfla_pkg::PAGE_W-1:0]  head;
  logic [pfla_pkg::COUNT_W-1:0] count;
  logic [pfla_pkg::PAGE_W-1:0]  grow_base;
  logic [K_W-1:0]               k;

  logic                         is_alloc;
  logic                         list_empty;
  logic                         over_cap;
  logic                         free_bad;
  logic                         do_push;
  logic                         do_grow;
  logic [pfla_pkg::PAGE_W-1:0]  link_page;
  logic [pfla_pkg::PAGE_W-1:0]  count_page;

  assign is_alloc   = (req.action == pfla_pkg::ACT_ALLOC);
  assign list_empty = (head == '0);
  assign over_cap   = ({1'b0, count} + GROW_L) > CAP_L;
  assign free_bad   = (req.page_number == '0) ||
                      ({1'b0, req.page_number} >= count);
  assign link_page  = grow_base + pfla_pkg::PAGE_W'(k);
  assign count_page = count[pfla_pkg::PAGE_W-1:0];

  always_comb begin
    state_next = state;
    unique case (state)
      pfla_pkg::ST_IDLE: begin
        if (fire && is_alloc) begin
          if (!list_empty) begin
            state_next = pfla_pkg::ST_POP;
          end else if (!over_cap) begin
            state_next = pfla_pkg::ST_GROW;
          end
        end
      end
      pfla_pkg::ST_POP: begin
        state_next = pfla_pkg::ST_IDLE;
      end
      pfla_pkg::ST_GROW: begin
        if (k == K_LAST) begin
          state_next = pfla_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = pfla_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    idle                    = 1'b0;
    res.valid               = 1'b0;
    res.data.allocated_page = '0;
    res.data.status         = pfla_pkg::STAT_DONE;
    mem_we                  = 1'b0;
    mem_waddr               = req.page_number;
    mem_wdata               = head;
    mem_raddr               = head;
    do_push                 = 1'b0;
    do_grow                 = 1'b0;
    unique case (state)
      pfla_pkg::ST_IDLE: begin
        idle      = 1'b1;
        res.valid = fire;
        if (is_alloc) begin
          if (!list_empty) begin
            res.data.allocated_page = head;
          end else if (over_cap) begin
            res.data.status = pfla_pkg::STAT_FULL;
          end else begin
            res.data.allocated_page = count_page;
            do_grow                 = fire;
          end
        end else if (free_bad) begin
          res.data.status = pfla_pkg::STAT_IGNORED;
        end else begin
          do_push = fire;
          mem_we  = fire;
        end
      end
      pfla_pkg::ST_POP: begin
      end
      pfla_pkg::ST_GROW: begin
        mem_we    = 1'b1;
        mem_waddr = link_page;
        mem_wdata = (k == K_LAST) ? '0 : link_page + 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pfla_pkg::ST_IDLE;
      head  <= '0;
      count <= pfla_pkg::COUNT_W'(1);
    end else begin
      state <= state_next;
      if (do_push) begin
        head <= req.page_number;
      end else if (do_grow) begin
        head  <= count_page + 1'b1;
        count <= count + pfla_pkg::COUNT_W'(GROW_PAGES);
      end else if (state == pfla_pkg::ST_POP) begin
        head <= mem_rdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_grow) begin
      grow_base <= count_page;
      k         <= K_FIRST;
    end else if (state == pfla_pkg::ST_GROW) begin
      k <= k + 1'b1;
    end
  end

endmodule

@@ design/page_free_list_allocator.sv @@
// Free-list page allocator.
// req channel (req_valid/req_ready/req): action allocate or free, page_number
// for a free. rsp channel (rsp_valid/rsp_ready/rsp): exactly one item per
// request, carrying allocated_page and status (done, out of capacity, free
// ignored).
// Each response is computed as the request is taken and is registered in
// the output stage. A free, a failed allocate and an ignored free leave the
// block idle; a pop then holds it in a pop state while the head's link is
// read from the link RAM, whose read port is registered. An allocate that
// finds the list empty grows the store and then writes GROW_PAGES-1 links,
// one per cycle through the single RAM write port, holding the block busy.
// A two-deep output stage lets one request be taken while a response waits;
// with both slots full req_ready stays low until rsp_ready drains one.
// Reset leaves an empty free list and a page count of one (header page).
// The link RAM needs no clearing: a link is always written before it is read.
module page_free_list_allocator #(
  parameter int MAX_PAGES  = pfla_pkg::MAX_PAGES_DEF,
  parameter int GROW_PAGES = pfla_pkg::GROW_PAGES_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  pfla_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output pfla_pkg::rsp_t rsp
);

  logic                        core_idle;
  logic                        fire;
  pfla_pkg::result_t           res;
  logic                        mem_we;
  logic [pfla_pkg::PAGE_W-1:0] mem_waddr;
  logic [pfla_pkg::PAGE_W-1:0] mem_wdata;
  logic [pfla_pkg::PAGE_W-1:0] mem_raddr;
  logic [pfla_pkg::PAGE_W-1:0] mem_rdata;
  logic                        hold_valid;
  pfla_pkg::rsp_t              hold;
  logic                        take;

  assign req_ready = core_idle && !hold_valid;
  assign fire      = req_valid && req_ready;
  assign take      = rsp_valid && rsp_ready;

  pfla_core #(
    .MAX_PAGES  (MAX_PAGES),
    .GROW_PAGES (GROW_PAGES)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .req       (req),
    .idle      (core_idle),
    .res       (res),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  pfla_ram #(
    .WIDTH (pfla_pkg::PAGE_W),
    .DEPTH (pfla_pkg::PAGE_SPACE)
  ) u_link_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // res.valid only occurs when hold is empty
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid  <= 1'b0;
      hold_valid <= 1'b0;
    end else begin
      if (res.valid) begin
        if (!rsp_valid || take) begin
          rsp_valid <= 1'b1;
          rsp       <= res.data;
        end else begin
          hold_valid <= 1'b1;
          hold       <= res.data;
        end
      end else if (take) begin
        rsp_valid  <= hold_valid;
        rsp        <= hold;
        hold_valid <= 1'b0;
      end
    end
  end

endmodule
